[src/dg_pkg.sv]
package dg_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int J_W     = 32;  // jacobian entry
  localparam int W_W     = 31;  // quadrature weight
  localparam int G_W     = 32;  // result entry
  localparam int P_W     = 64;  // product of two entries
  localparam int A_W     = 65;  // adjugate entry
  localparam int S_W     = 130; // adjugate dot product
  localparam int SM_W    = 129; // magnitude of a dot product
  localparam int DET_W   = 97;  // determinant
  localparam int DETM_W  = 96;  // determinant magnitude
  localparam int NUM_W   = W_W + SM_W;
  localparam int N_GEO   = 6;
  localparam int N_JAC   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_DIM = 1'd1;
  localparam logic [CFG_W-1:0]     DIM_RESET     = 2'd3;

  // dimension + 10 * space_dimension
  localparam logic [5:0] PAIR_SCALE = 6'd10;
  localparam logic [5:0] PAIR_11    = 6'd11;
  localparam logic [5:0] PAIR_22    = 6'd22;
  localparam logic [5:0] PAIR_33    = 6'd33;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIM  = 2'd1;
  localparam logic [1:0] ST_ZERO_DET = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  // jacobian slots, column major: 11 21 31 12 22 32 13 23 33
  localparam int J11 = 0, J21 = 1, J31 = 2, J12 = 3, J22 = 4;
  localparam int J32 = 5, J13 = 6, J23 = 7, J33 = 8;

  // cofactor a_k = j[PA_X]*j[PA_Y] - j[PB_X]*j[PB_Y], rows a1*, a2*, a3*
  localparam int PA_X [N_JAC] = '{J22, J13, J12, J23, J11, J13, J21, J12, J11};
  localparam int PA_Y [N_JAC] = '{J33, J32, J23, J31, J33, J21, J32, J31, J22};
  localparam int PB_X [N_JAC] = '{J23, J12, J13, J21, J13, J11, J22, J11, J12};
  localparam int PB_Y [N_JAC] = '{J32, J33, J22, J33, J31, J23, J31, J32, J21};

  // upper triangle of adj * adj^T, row by row
  localparam int ROW_A [N_GEO] = '{0, 0, 0, 1, 1, 2};
  localparam int ROW_B [N_GEO] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [1:0] {
    MODE_BAD,
    MODE_1D,
    MODE_2D,
    MODE_3D
  } mode_t;

  typedef struct packed {
    logic [N_JAC-1:0][J_W-1:0] jac;
    logic [W_W-1:0]            weight;
    logic                      last;
    mode_t                     mode;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic             last;
    logic [1:0]       pre;
    logic [N_GEO-1:0] sneg;
    logic             den_neg;
    logic [N_GEO-1:0] ovf;
  } dv_meta_t;

endpackage

[src/dg_if.sv]
interface dg_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  jac_11;
  logic signed [31:0]  jac_21;
  logic signed [31:0]  jac_31;
  logic signed [31:0]  jac_12;
  logic signed [31:0]  jac_22;
  logic signed [31:0]  jac_32;
  logic signed [31:0]  jac_13;
  logic signed [31:0]  jac_23;
  logic signed [31:0]  jac_33;
  logic        [30:0]  weight;
  logic                last_point;

  modport source(output valid, jac_11, jac_21, jac_31, jac_12, jac_22, jac_32,
                 jac_13, jac_23, jac_33, weight, last_point, input ready);
  modport sink(input valid, jac_11, jac_21, jac_31, jac_12, jac_22, jac_32,
               jac_13, jac_23, jac_33, weight, last_point, output ready);
endinterface

interface dg_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  geo_0;
  logic signed [31:0]  geo_1;
  logic signed [31:0]  geo_2;
  logic signed [31:0]  geo_3;
  logic signed [31:0]  geo_4;
  logic signed [31:0]  geo_5;
  logic        [1:0]   status;
  logic                last_out;

  modport source(output valid, geo_0, geo_1, geo_2, geo_3, geo_4, geo_5, status,
                 last_out, input ready);
  modport sink(input valid, geo_0, geo_1, geo_2, geo_3, geo_4, geo_5, status,
               last_out, output ready);
endinterface

[src/dg_front.sv]
module dg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  dg_in_if.sink                         in_ch,
  input  logic                          cfg_we,
  input  logic [dg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dg_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                          q_full,
  output dg_pkg::q_push_t               q_push
);
  import dg_pkg::*;

  logic [CFG_W-1:0] dim_r, sdim_r;
  logic [5:0]       pair;
  mode_t            mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= DIM_RESET;
      sdim_r <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DIMENSION) dim_r  <= cfg_wdata;
      if (cfg_idx == CFG_SPACE_DIM) sdim_r <= cfg_wdata;
    end
  end

  assign pair = {4'd0, dim_r} + PAIR_SCALE * {4'd0, sdim_r};

  always_comb begin
    unique case (pair)
      PAIR_11: mode = MODE_1D;
      PAIR_22: mode = MODE_2D;
      PAIR_33: mode = MODE_3D;
      default: mode = MODE_BAD;
    endcase
  end

  assign in_ch.ready = !q_full;

  always_comb begin
    q_push.valid          = in_ch.valid && !q_full;
    q_push.item.jac[J11]  = in_ch.jac_11;
    q_push.item.jac[J21]  = in_ch.jac_21;
    q_push.item.jac[J31]  = in_ch.jac_31;
    q_push.item.jac[J12]  = in_ch.jac_12;
    q_push.item.jac[J22]  = in_ch.jac_22;
    q_push.item.jac[J32]  = in_ch.jac_32;
    q_push.item.jac[J13]  = in_ch.jac_13;
    q_push.item.jac[J23]  = in_ch.jac_23;
    q_push.item.jac[J33]  = in_ch.jac_33;
    q_push.item.weight    = in_ch.weight;
    q_push.item.last      = in_ch.last_point;
    q_push.item.mode      = mode;
  end

endmodule

[src/dg_fifo.sv]
module dg_fifo #(
  parameter int DEPTH = dg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dg_pkg::q_push_t q_push,
  output logic            q_full,
  input  logic            q_pop,
  output dg_pkg::q_head_t q_head
);
  import dg_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop;

  assign q_full      = (cnt_r == (PTR_W+1)'(DEPTH));
  assign push        = q_push.valid && !q_full;
  assign pop         = q_pop && (cnt_r != '0);
  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= q_push.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[src/dg_back.sv]
module dg_back #(
  parameter int FRAC_BITS = dg_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dg_pkg::q_head_t q_head,
  output logic            q_pop,
  dg_out_if.source        out_ch
);
  import dg_pkg::*;

  localparam int DEN_W = DETM_W + FRAC_BITS;
  localparam int DV_W  = ((NUM_W > DEN_W + G_W) ? NUM_W : DEN_W + G_W) + 1;
  localparam int N_PRE = 7;
  localparam int NST   = N_PRE + G_W + 1;
  localparam int H_W   = A_W - J_W;   // upper part of an adjugate entry
  localparam int PP_W  = 2 * H_W;     // partial product of two parts
  localparam int N_CH  = 5;           // 32-bit chunks of a dot product magnitude
  localparam int NP_W  = W_W + G_W;   // weight times one chunk

  logic           en;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;

  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en && q_head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], q_head.valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // stage 1: the eighteen cofactor products
  logic signed [P_W-1:0] pa_r [N_JAC];
  logic signed [P_W-1:0] pb_r [N_JAC];
  q_item_t               m1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_JAC; k++) begin
        pa_r[k] <= $signed(q_head.item.jac[PA_X[k]]) * $signed(q_head.item.jac[PA_Y[k]]);
        pb_r[k] <= $signed(q_head.item.jac[PB_X[k]]) * $signed(q_head.item.jac[PB_Y[k]]);
      end
      m1_r <= q_head.item;
    end
  end

  // stage 2: adjugate rows and determinant operands per dimension
  logic signed [A_W-1:0] a3 [N_JAC];
  logic signed [A_W-1:0] au [N_JAC];
  logic signed [J_W-1:0] dj [3];
  logic signed [A_W-1:0] da [3];
  logic signed [A_W-1:0] au_r [N_JAC];
  logic signed [J_W-1:0] dj_r [3];
  logic signed [A_W-1:0] da_r [3];
  q_item_t               m2_r;

  always_comb begin
    for (int k = 0; k < N_JAC; k++) begin
      a3[k] = A_W'(pa_r[k]) - A_W'(pb_r[k]);
      au[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      dj[k] = '0;
      da[k] = '0;
    end
    dj[0] = J_W'(1);
    unique case (m1_r.mode)
      MODE_3D: begin
        for (int k = 0; k < N_JAC; k++) au[k] = a3[k];
        dj[0] = $signed(m1_r.jac[J11]);
        dj[1] = $signed(m1_r.jac[J21]);
        dj[2] = $signed(m1_r.jac[J31]);
        for (int k = 0; k < 3; k++) da[k] = a3[k];
      end
      MODE_2D: begin
        // adj = [j22 -j12; -j21 j11], det = j11 j22 - j12 j21
        au[0] = A_W'($signed(m1_r.jac[J22]));
        au[1] = -A_W'($signed(m1_r.jac[J12]));
        au[3] = -A_W'($signed(m1_r.jac[J21]));
        au[4] = A_W'($signed(m1_r.jac[J11]));
        da[0] = a3[8];
      end
      MODE_1D: da[0] = A_W'($signed(m1_r.jac[J11]));
      default: da[0] = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      au_r <= au;
      dj_r <= dj;
      da_r <= da;
      m2_r <= m1_r;
    end
  end

  // stage 3: partial products, each wide operand split into a signed upper
  // part and a zero-extended lower 32 bits
  logic signed [H_W-1:0]  ah [N_JAC];
  logic signed [H_W-1:0]  al [N_JAC];
  logic signed [H_W-1:0]  dh [3];
  logic signed [H_W-1:0]  dl [3];
  logic signed [PP_W-1:0] pp_hh_r [N_GEO][3];
  logic signed [PP_W-1:0] pp_hl_r [N_GEO][3];
  logic signed [PP_W-1:0] pp_lh_r [N_GEO][3];
  logic signed [PP_W-1:0] pp_ll_r [N_GEO][3];
  logic signed [A_W-1:0]  dph_r [3];
  logic signed [A_W-1:0]  dpl_r [3];
  q_item_t                m3p_r;

  always_comb begin
    for (int k = 0; k < N_JAC; k++) begin
      ah[k] = au_r[k][A_W-1:J_W];
      al[k] = {1'b0, au_r[k][J_W-1:0]};
    end
    for (int m = 0; m < 3; m++) begin
      dh[m] = da_r[m][A_W-1:J_W];
      dl[m] = {1'b0, da_r[m][J_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_GEO; i++) begin
        for (int m = 0; m < 3; m++) begin
          pp_hh_r[i][m] <= ah[ROW_A[i]*3+m] * ah[ROW_B[i]*3+m];
          pp_hl_r[i][m] <= ah[ROW_A[i]*3+m] * al[ROW_B[i]*3+m];
          pp_lh_r[i][m] <= al[ROW_A[i]*3+m] * ah[ROW_B[i]*3+m];
          pp_ll_r[i][m] <= al[ROW_A[i]*3+m] * al[ROW_B[i]*3+m];
        end
      end
      for (int m = 0; m < 3; m++) begin
        dph_r[m] <= dj_r[m] * dh[m];
        dpl_r[m] <= dj_r[m] * dl[m];
      end
      m3p_r <= m2_r;
    end
  end

  // stage 4: dot product terms and determinant terms from the partials
  logic signed [S_W-1:0]   t_r  [N_GEO][3];
  logic signed [DET_W-1:0] dp_r [3];
  q_item_t                 m3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_GEO; i++) begin
        for (int m = 0; m < 3; m++) begin
          // low partial is non-negative and below 2^64, so it packs under the high one
          t_r[i][m] <= $signed({pp_hh_r[i][m], pp_ll_r[i][m][2*J_W-1:0]})
                       + (S_W'(pp_hl_r[i][m]) <<< J_W) + (S_W'(pp_lh_r[i][m]) <<< J_W);
        end
      end
      for (int m = 0; m < 3; m++) dp_r[m] <= (DET_W'(dph_r[m]) <<< J_W) + DET_W'(dpl_r[m]);
      m3_r <= m3p_r;
    end
  end

  // stage 5: sums, lane selection, magnitudes
  logic signed [S_W-1:0]   s [N_GEO];
  logic signed [S_W-1:0]   s_sel [N_GEO];
  logic signed [DET_W-1:0] det;
  logic [DETM_W-1:0]       det_mag;
  logic [SM_W-1:0]         smag_r [N_GEO];
  logic [N_GEO-1:0]        sneg_r;
  logic [DEN_W-1:0]        den4_r;
  logic                    den_neg4_r;
  logic [1:0]              pre4_r;
  logic [W_W-1:0]          w4_r;
  logic                    last4_r;

  always_comb begin
    for (int i = 0; i < N_GEO; i++) begin
      s[i]     = t_r[i][0] + t_r[i][1] + t_r[i][2];
      s_sel[i] = '0;
    end
    det     = dp_r[0] + dp_r[1] + dp_r[2];
    det_mag = det[DET_W-1] ? DETM_W'(-det) : DETM_W'(det);
    unique case (m3_r.mode)
      MODE_3D: s_sel = s;
      MODE_2D: begin
        s_sel[0] = s[0];
        s_sel[1] = s[1];
        s_sel[2] = s[3];
      end
      MODE_1D: s_sel[0] = S_W'(1) <<< FRAC_BITS;
      default: s_sel[0] = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_GEO; i++) begin
        smag_r[i] <= s_sel[i][S_W-1] ? SM_W'(-s_sel[i]) : SM_W'(s_sel[i]);
        sneg_r[i] <= s_sel[i][S_W-1];
      end
      den4_r     <= (m3_r.mode == MODE_3D) ? (DEN_W'(det_mag) << FRAC_BITS)
                                           : DEN_W'(det_mag);
      den_neg4_r <= det[DET_W-1];
      if (m3_r.mode == MODE_BAD) pre4_r <= ST_BAD_DIM;
      else if (det == '0)        pre4_r <= ST_ZERO_DET;
      else                       pre4_r <= ST_OK;
      w4_r    <= m3_r.weight;
      last4_r <= m3_r.last;
    end
  end

  // stage 6: weight times each 32-bit chunk of the magnitudes
  logic [N_CH*G_W-1:0] smx [N_GEO];
  logic [NP_W-1:0]     np_r [N_GEO][N_CH];
  logic [DEN_W-1:0]    den6_r;
  dv_meta_t            meta6_r;

  always_comb begin
    for (int i = 0; i < N_GEO; i++) smx[i] = (N_CH*G_W)'(smag_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_GEO; i++) begin
        for (int c = 0; c < N_CH; c++) begin
          np_r[i][c] <= NP_W'(w4_r) * NP_W'(smx[i][c*G_W +: G_W]);
        end
      end
      den6_r          <= den4_r;
      meta6_r.last    <= last4_r;
      meta6_r.pre     <= pre4_r;
      meta6_r.sneg    <= sneg_r;
      meta6_r.den_neg <= den_neg4_r;
      meta6_r.ovf     <= '0;
    end
  end

  // stage 7: numerator magnitudes, even and odd chunks do not overlap
  logic [NUM_W-1:0] num_r [N_GEO];
  logic [DEN_W-1:0] den5_r;
  dv_meta_t         meta5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_GEO; i++) begin
        num_r[i] <= {np_r[i][4][G_W-1:0], 1'b0, np_r[i][2], 1'b0, np_r[i][0]}
                  + {1'b0, np_r[i][3], 1'b0, np_r[i][1], {G_W{1'b0}}};
      end
      den5_r  <= den6_r;
      meta5_r <= meta6_r;
    end
  end

  // divider: overflow check, then one quotient bit per stage
  logic [DV_W-1:0]  rem_r [G_W+1][N_GEO];
  logic [G_W-1:0]   quo_r [G_W+1][N_GEO];
  logic [DEN_W-1:0] dden_r [G_W+1];
  dv_meta_t         dmeta_r [G_W+1];
  dv_meta_t         meta0;

  always_comb begin
    meta0 = meta5_r;
    for (int l = 0; l < N_GEO; l++) begin
      meta0.ovf[l] = DV_W'(num_r[l]) >= (DV_W'(den5_r) << G_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < N_GEO; l++) begin
        rem_r[0][l] <= DV_W'(num_r[l]);
        quo_r[0][l] <= '0;
      end
      dden_r[0]  <= den5_r;
      dmeta_r[0] <= meta0;
    end
  end

  for (genvar k = 0; k < G_W; k++) begin : g_div
    localparam int BIT = G_W - 1 - k;
    logic [DV_W-1:0] trial;
    assign trial = DV_W'(dden_r[k]) << BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < N_GEO; l++) begin
          if (rem_r[k][l] >= trial) begin
            rem_r[k+1][l]      <= rem_r[k][l] - trial;
            quo_r[k+1][l]      <= quo_r[k][l] | (G_W'(1) << BIT);
          end else begin
            rem_r[k+1][l]      <= rem_r[k][l];
            quo_r[k+1][l]      <= quo_r[k][l];
          end
        end
        dden_r[k+1]  <= dden_r[k];
        dmeta_r[k+1] <= dmeta_r[k];
      end
    end
  end

  // sign, saturation, status
  logic signed [G_W-1:0] geo [N_GEO];
  logic [N_GEO-1:0]      sat;
  logic [1:0]            status;
  logic signed [G_W-1:0] geo_r [N_GEO];
  logic [1:0]            status_r;
  logic                  last_r;

  always_comb begin
    dv_meta_t        mt;
    logic [G_W-1:0]  q, lim, val;
    logic            neg;
    mt = dmeta_r[G_W];
    for (int l = 0; l < N_GEO; l++) begin
      q      = quo_r[G_W][l];
      neg    = (mt.sneg[l] ^ mt.den_neg) && ((q != '0) || mt.ovf[l]);
      lim    = neg ? {1'b1, {(G_W-1){1'b0}}} : {1'b0, {(G_W-1){1'b1}}};
      sat[l] = mt.ovf[l] || (q > lim);
      val    = sat[l] ? lim : q;
      geo[l] = neg ? -$signed(val) : $signed(val);
    end
    if (mt.pre != ST_OK) begin
      status = mt.pre;
      for (int l = 0; l < N_GEO; l++) geo[l] = '0;
    end else begin
      status = (sat != '0) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r    <= geo;
      status_r <= status;
      last_r   <= dmeta_r[G_W].last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.geo_0    = geo_r[0];
  assign out_ch.geo_1    = geo_r[1];
  assign out_ch.geo_2    = geo_r[2];
  assign out_ch.geo_3    = geo_r[3];
  assign out_ch.geo_4    = geo_r[4];
  assign out_ch.geo_5    = geo_r[5];
  assign out_ch.status   = status_r;
  assign out_ch.last_out = last_r;

endmodule

[src/diffusion_geometric_factors.sv]
// channel | dir | handshake         | content
// in_ch   | in  | valid/ready       | jacobian 3x3, weight, last_point
// out_ch  | out | valid/ready       | geo_0..geo_5, status, last_out
// cfg_*   | in  | write enable only | dimension, space_dimension
//
// one quadrature point per cycle sustained while out_ch is ready; from queue head
// to result: 7 arithmetic stages, the overflow check, the 32-stage restoring
// divider and the output register; points reach the queue head through the input queue
// synchronous active-low reset clears config to 3/3, queue and stage valids
// an output stall freezes the whole back pipeline; the input queue keeps
// taking points until it fills
module diffusion_geometric_factors #(
  parameter int FRAC_BITS   = dg_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = dg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dg_in_if.sink                         in_ch,
  dg_out_if.source                      out_ch,
  input  logic                          cfg_we,
  input  logic [dg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dg_pkg::CFG_W-1:0]      cfg_wdata
);
  import dg_pkg::*;

  q_push_t q_push;   // classified point into the queue
  q_head_t q_head;   // oldest queued point
  logic    q_full;
  logic    q_pop;

  // front: config registers, dimension pair decode, input transfer
  dg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // short queue decoupling input transfers from back-end stalls
  dg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  // back: adjugate, dot products, scaling and division
  dg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // unsupported dimensions give all-zero factors
  a_bad_dim_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_BAD_DIM) |->
      (out_ch.geo_0 == '0 && out_ch.geo_1 == '0 && out_ch.geo_2 == '0 &&
       out_ch.geo_3 == '0 && out_ch.geo_4 == '0 && out_ch.geo_5 == '0))
    else $error("nonzero factor on unsupported dimensions");

  // zero determinant gives all-zero factors
  a_zero_det_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_ZERO_DET) |->
      (out_ch.geo_0 == '0 && out_ch.geo_1 == '0 && out_ch.geo_2 == '0 &&
       out_ch.geo_3 == '0 && out_ch.geo_4 == '0 && out_ch.geo_5 == '0))
    else $error("nonzero factor on zero determinant");

  // a pop never happens on an empty queue
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

endmodule
